### hw/rtl/sobe_pkg.sv
// ----------------------------------------------------------------------------
// sobe_pkg: shared types and constants of the Sobel edge threshold unit
// Register indexes, reset values, window column type and line store request.
// ----------------------------------------------------------------------------
package sobe_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field widths
    localparam int PIX_W   = 8;
    localparam int WID_W   = 12;
    localparam int HGT_W   = 13;
    localparam int ROW_W   = HGT_W + 1;
    localparam int THR_W   = 10;
    localparam int WGT_W   = 16;
    localparam int CNT_W   = 24;
    localparam int PROD_W  = PIX_W + WGT_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 16;
    localparam int GSUM_W  = PIX_W + 2;
    localparam int GRAD_W  = PIX_W + 3;

    // Register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_WIDTH     = 3'd0,
        CFG_HEIGHT    = 3'd1,
        CFG_DIRECTION = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_BLUE_WGT  = 3'd4,
        CFG_GREEN_WGT = 3'd5,
        CFG_RED_WGT   = 3'd6
    } t_cfg_idx;

    // Command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Kernel select
    localparam logic DIR_X = 1'b0;
    localparam logic DIR_Y = 1'b1;

    // Reset values
    localparam logic [WID_W-1:0]  RST_WIDTH     = 12'd640;
    localparam logic [HGT_W-1:0]  RST_HEIGHT    = 13'd480;
    localparam logic              RST_DIRECTION = DIR_X;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 10'd70;
    localparam logic [WGT_W-1:0]  RST_BLUE_WGT  = 16'd7471;
    localparam logic [WGT_W-1:0]  RST_GREEN_WGT = 16'd38470;
    localparam logic [WGT_W-1:0]  RST_RED_WGT   = 16'd19595;
    localparam logic [CNT_W-1:0]  RST_TOTAL     = 24'd307200;

    // Output levels
    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    // One column of the 3x3 window, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // Line store word: older line above, newer line below
    typedef struct packed {
        logic [PIX_W-1:0] prev2;
        logic [PIX_W-1:0] prev;
    } t_lb_word;

    // Line store access for one cycle
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        t_lb_word         wr_data;
    } t_lb_req;

endpackage

### hw/rtl/sobe_cell.sv
// ----------------------------------------------------------------------------
// sobe_cell: one column cell of the 3x3 window
// Holds three gray values, hands them to the next cell on each shift and
// forms the column terms of both Sobel kernels.
// ----------------------------------------------------------------------------
module sobe_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  sobe_pkg::t_col                      i_col,
    output sobe_pkg::t_col                      o_col,
    output logic [sobe_pkg::GSUM_W-1:0]         o_sum,
    output logic signed [sobe_pkg::PIX_W:0]     o_diff
);
    import sobe_pkg::*;

    t_col r_col;

    // Load the neighbor's column on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // Weighted column sum for the x kernel
    assign o_sum = GSUM_W'(r_col.top) + {1'b0, r_col.mid, 1'b0} + GSUM_W'(r_col.bot);

    // Bottom minus top for the y kernel
    assign o_diff = $signed({1'b0, r_col.bot}) - $signed({1'b0, r_col.top});

endmodule

### hw/rtl/sobe_line_buf.sv
// ----------------------------------------------------------------------------
// sobe_line_buf: two gray line stores in one memory
// Registered read with forwarding of a write to the same column in the
// same cycle.
// ----------------------------------------------------------------------------
module sobe_line_buf (
    input  logic                i_clk,
    input  sobe_pkg::t_lb_req   i_req,
    output sobe_pkg::t_lb_word  o_rd_data
);
    import sobe_pkg::*;

    t_lb_word r_mem [MAX_WIDTH];
    t_lb_word r_rd;
    t_lb_word r_fwd;
    logic     r_fwd_sel;

    // Write the updated column, read the next one
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd      <= r_mem[i_req.rd_addr];
            r_fwd     <= i_req.wr_data;
            r_fwd_sel <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
        end
    end

    assign o_rd_data = r_fwd_sel ? r_fwd : r_rd;

endmodule

### hw/rtl/sobel_edge_threshold_3x3_unit.sv
// ----------------------------------------------------------------------------
// A result passes stage 1, stage 2 and the output register before it is
// shown on o_valid; results trail pixels by one row plus one pixel.
// Throughput: one item per cycle while o_stall is low; o_stall is high
// while the skid stage is full and in the cycle after each register write.
// Reset: control state, counters, window and registers return to defaults;
// the line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_threshold_3x3_unit: gray conversion and 3x3 Sobel threshold
// Front end counts the raster, a chain of window cells forms the kernel,
// a skid stage separates the result channel.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_3x3_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pixel channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [sobe_pkg::PIX_W-1:0]          i_blue_in,
    input  logic [sobe_pkg::PIX_W-1:0]          i_green_in,
    input  logic [sobe_pkg::PIX_W-1:0]          i_red_in,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sobe_pkg::PIX_W-1:0]          o_pixel_value,
    output logic                                o_last_of_frame,
    // Register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sobe_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [sobe_pkg::CDAT_W-1:0]         i_cfg_data
);
    import sobe_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic             r_dir;
    logic [THR_W-1:0] r_thr;
    logic [WGT_W-1:0] r_bw;
    logic [WGT_W-1:0] r_gw;
    logic [WGT_W-1:0] r_rw;
    logic             r_cfg_hold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_dir      <= RST_DIRECTION;
            r_thr      <= RST_THRESHOLD;
            r_bw       <= RST_BLUE_WGT;
            r_gw       <= RST_GREEN_WGT;
            r_rw       <= RST_RED_WGT;
            r_cfg_hold <= 1'b0;
        end else begin
            r_cfg_hold <= i_cfg_valid;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:     r_width  <= i_cfg_data[WID_W-1:0];
                    CFG_HEIGHT:    r_height <= i_cfg_data[HGT_W-1:0];
                    CFG_DIRECTION: r_dir    <= i_cfg_data[0];
                    CFG_THRESHOLD: r_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_BLUE_WGT:  r_bw     <= i_cfg_data[WGT_W-1:0];
                    CFG_GREEN_WGT: r_gw     <= i_cfg_data[WGT_W-1:0];
                    CFG_RED_WGT:   r_rw     <= i_cfg_data[WGT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Frame geometry, clamped and registered from the register values
    logic [WID_W-1:0] n_w_eff;
    logic [HGT_W-1:0] n_h_eff;
    logic [WID_W-1:0] r_w_eff;
    logic [HGT_W-1:0] r_hm1;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_total_m1;
    logic [WID_W+HGT_W-1:0] w_area;

    always_comb begin
        if (r_width == '0) begin
            n_w_eff = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            n_w_eff = WID_W'(MAX_WIDTH);
        end else begin
            n_w_eff = r_width;
        end
        n_h_eff = (r_height == '0) ? HGT_W'(1) : r_height;
        w_area  = n_w_eff * n_h_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff    <= RST_WIDTH;
            r_hm1      <= RST_HEIGHT - HGT_W'(1);
            r_total    <= RST_TOTAL;
            r_total_m1 <= RST_TOTAL - CNT_W'(1);
        end else begin
            r_w_eff    <= n_w_eff;
            r_hm1      <= n_h_eff - HGT_W'(1);
            r_total    <= w_area[CNT_W-1:0];
            r_total_m1 <= w_area[CNT_W-1:0] - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline advance
    // ------------------------------------------------------------------
    logic r_skid_full;
    logic w_adv;
    logic w_accept;

    assign w_adv    = !r_skid_full;
    assign o_stall  = r_skid_full || r_cfg_hold;
    assign w_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Raster counters (front end)
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [CNT_W-1:0] n_cnt;

    logic [COL_W-1:0] w_col0;
    logic [ROW_W-1:0] w_row0;
    logic [CNT_W-1:0] w_cnt0;
    logic             w_flush;
    logic             w_ignore;
    logic             w_take;
    logic             w_emit;
    logic             w_last;
    logic             w_border;
    logic [ROW_W-1:0] w_orow;
    logic [WID_W-1:0] w_col_inc;

    always_comb begin
        // Drop a finished frame left over from a geometry change
        if (r_cnt >= r_total) begin
            w_col0 = '0;
            w_row0 = '0;
            w_cnt0 = '0;
        end else begin
            w_col0 = r_col;
            w_row0 = r_row;
            w_cnt0 = r_cnt;
        end
        w_flush   = (i_cmd == CMD_FLUSH);
        w_ignore  = w_flush && (w_row0 == '0) && (w_col0 == '0);
        w_take    = w_accept && !w_ignore;
        w_emit    = (w_row0 >= ROW_W'(2)) || ((w_row0 == ROW_W'(1)) && (w_col0 != '0));
        w_last    = w_emit && (w_cnt0 == r_total_m1);
        w_orow    = (w_col0 != '0) ? (w_row0 - ROW_W'(1)) : (w_row0 - ROW_W'(2));
        w_col_inc = WID_W'(w_col0) + WID_W'(1);
        w_border  = (w_orow == '0) || (w_orow >= ROW_W'(r_hm1)) ||
                    (w_col0 == '0) || (w_col0 == COL_W'(1)) ||
                    (WID_W'(w_col0) >= r_w_eff);

        // Advance the raster position
        n_col = r_col;
        n_row = r_row;
        n_cnt = r_cnt;
        if (w_accept) begin
            n_col = w_col0;
            n_row = w_row0;
            n_cnt = w_cnt0;
            if (!w_ignore) begin
                if (w_col_inc >= r_w_eff) begin
                    n_col = '0;
                    n_row = w_row0 + ROW_W'(1);
                end else begin
                    n_col = w_col_inc[COL_W-1:0];
                end
                n_cnt = w_cnt0 + CNT_W'(w_emit);
                if (w_last) begin
                    n_col = '0;
                    n_row = '0;
                    n_cnt = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_cnt <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: gray products and line store read
    // ------------------------------------------------------------------
    logic              r1_valid;
    logic              r1_flush;
    logic              r1_emit;
    logic              r1_border;
    logic              r1_last;
    logic [COL_W-1:0]  r1_col;
    logic [PROD_W-1:0] r1_pb;
    logic [PROD_W-1:0] r1_pg;
    logic [PROD_W-1:0] r1_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r1_flush  <= w_flush;
            r1_emit   <= w_emit;
            r1_border <= w_border;
            r1_last   <= w_last;
            r1_col    <= w_col0;
            r1_pb     <= i_blue_in * r_bw;
            r1_pg     <= i_green_in * r_gw;
            r1_pr     <= i_red_in * r_rw;
        end
    end

    // Sum, truncate and saturate the gray value
    logic [SUM_W-1:0] w_gsum;
    logic [PIX_W-1:0] w_gray;

    always_comb begin
        w_gsum = SUM_W'(r1_pb) + SUM_W'(r1_pg) + SUM_W'(r1_pr);
        if (r1_flush) begin
            w_gray = PIX_ZERO;
        end else if (|w_gsum[SUM_W-1:WGT_W+PIX_W]) begin
            w_gray = PIX_MAX;
        end else begin
            w_gray = w_gsum[WGT_W+PIX_W-1:WGT_W];
        end
    end

    // Line store: read at transfer, write back when the item leaves stage 1
    t_lb_req  w_lb_req;
    t_lb_word w_lb_rd;

    always_comb begin
        w_lb_req.rd_en         = w_take;
        w_lb_req.rd_addr       = w_col0;
        w_lb_req.wr_en         = w_adv && r1_valid;
        w_lb_req.wr_addr       = r1_col;
        w_lb_req.wr_data.prev2 = w_lb_rd.prev;
        w_lb_req.wr_data.prev  = w_gray;
    end

    sobe_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_req     (w_lb_req),
        .o_rd_data (w_lb_rd)
    );

    // ------------------------------------------------------------------
    // Window: chain of three column cells, newest on the right
    // ------------------------------------------------------------------
    logic                     w_shift;
    t_col                     w_new_col;
    t_col                     w_c2;
    t_col                     w_c1;
    t_col                     w_c0;
    logic [GSUM_W-1:0]        w_s2;
    logic [GSUM_W-1:0]        w_s1;
    logic [GSUM_W-1:0]        w_s0;
    logic signed [PIX_W:0]    w_d2;
    logic signed [PIX_W:0]    w_d1;
    logic signed [PIX_W:0]    w_d0;

    assign w_shift       = w_adv && r1_valid;
    assign w_new_col.top = w_lb_rd.prev2;
    assign w_new_col.mid = w_lb_rd.prev;
    assign w_new_col.bot = w_gray;

    sobe_cell u_cell2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (w_shift),
        .i_col (w_new_col), .o_col (w_c2), .o_sum (w_s2), .o_diff (w_d2)
    );
    sobe_cell u_cell1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (w_shift),
        .i_col (w_c2), .o_col (w_c1), .o_sum (w_s1), .o_diff (w_d1)
    );
    sobe_cell u_cell0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (w_shift),
        .i_col (w_c1), .o_col (w_c0), .o_sum (w_s0), .o_diff (w_d0)
    );

    // ------------------------------------------------------------------
    // Stage 2: gradient and threshold
    // ------------------------------------------------------------------
    logic r2_valid;
    logic r2_border;
    logic r2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid && r1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r2_border <= r1_border;
            r2_last   <= r1_last;
        end
    end

    logic signed [GRAD_W-1:0] w_grad;
    logic [GRAD_W-1:0]        w_mag;
    logic [PIX_W-1:0]         w_value;

    always_comb begin
        if (r_dir == DIR_Y) begin
            w_grad = GRAD_W'(w_d0) + (GRAD_W'(w_d1) <<< 1) + GRAD_W'(w_d2);
        end else begin
            w_grad = $signed({1'b0, w_s2}) - $signed({1'b0, w_s0});
        end
        w_mag = w_grad[GRAD_W-1] ? GRAD_W'(-w_grad) : GRAD_W'(w_grad);
        if (r2_border) begin
            w_value = w_c1.mid;
        end else if (w_mag >= GRAD_W'(r_thr)) begin
            w_value = PIX_MAX;
        end else begin
            w_value = PIX_ZERO;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic             w_push;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;
    logic [PIX_W-1:0] r_skid_pix;
    logic             r_skid_last;

    assign w_push = w_adv && r2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_full) begin
                r_out_valid <= 1'b1;
                r_skid_full <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_full) begin
                r_out_pix  <= r_skid_pix;
                r_out_last <= r_skid_last;
            end else if (w_push) begin
                r_out_pix  <= w_value;
                r_out_last <= r2_last;
            end
        end else if (w_push) begin
            r_skid_pix  <= w_value;
            r_skid_last <= r2_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_value   = r_out_pix;
    assign o_last_of_frame = r_out_last;

endmodule

### tb/tb_sobel_edge_threshold_3x3_unit.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold_3x3_unit: self-checking bench of the Sobel unit
// Feeds raster frames of BGR pixels and flush ticks with random bursts and
// result backpressure. A cycle-free model of the gray conversion, line
// stores and 3x3 kernel predicts each result, which is checked field by field
// against what the unit delivers.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold_3x3_unit;

    import sobe_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 10;
    localparam int PRINT_LIMIT = 200;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_PAUSE,
        STEP_WRITE
    } step_kind_e;

    typedef struct {
        step_kind_e        kind;
        logic              cmd;
        logic [PIX_W-1:0]  blue;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  red;
        t_cfg_idx          reg_idx;
        logic [CDAT_W-1:0] reg_data;
    } stim_step_t;

    typedef struct {
        logic [PIX_W-1:0] value;
        logic             frame_end;
    } pix_result_t;

    // Clock, reset and unit ports
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic               i_cmd           = CMD_PIXEL;
    logic [PIX_W-1:0]   i_blue_in       = '0;
    logic [PIX_W-1:0]   i_green_in      = '0;
    logic [PIX_W-1:0]   i_red_in        = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [PIX_W-1:0]   o_pixel_value;
    logic               o_last_of_frame;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index     = '0;
    logic [CDAT_W-1:0]  i_cfg_data      = '0;

    // Stimulus and expected results
    stim_step_t  step_q[$];
    pix_result_t result_q[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          frame_items    = 0;

    // Register copies seen by the stimulus generator
    logic [WID_W-1:0] gen_width  = RST_WIDTH;
    logic [HGT_W-1:0] gen_height = RST_HEIGHT;

    // Predictor registers and state
    logic [WID_W-1:0]  reg_width     = RST_WIDTH;
    logic [HGT_W-1:0]  reg_height    = RST_HEIGHT;
    logic              reg_direction = RST_DIRECTION;
    logic [THR_W-1:0]  reg_threshold = RST_THRESHOLD;
    logic [WGT_W-1:0]  reg_blue_w    = RST_BLUE_WGT;
    logic [WGT_W-1:0]  reg_green_w   = RST_GREEN_WGT;
    logic [WGT_W-1:0]  reg_red_w     = RST_RED_WGT;
    logic [PIX_W-1:0]  gray_row1 [MAX_WIDTH];
    logic [PIX_W-1:0]  gray_row2 [MAX_WIDTH];
    logic [PIX_W-1:0]  win_px [9];
    int unsigned       ras_col   = 0;
    int unsigned       ras_row   = 0;
    logic [CNT_W-1:0]  res_count = '0;

    // Driver pacing
    int gap_left    = 0;
    int burst_left  = 1;
    int settle_left = SETTLE;

    // Receiver stall pattern
    int pat_mode = 0;
    int pat_left = 0;

    sobel_edge_threshold_3x3_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_blue_in       (i_blue_in),
        .i_green_in      (i_green_in),
        .i_red_in        (i_red_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_value   (o_pixel_value),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < MAX_WIDTH; k++) begin
            gray_row1[k] = '0;
            gray_row2[k] = '0;
        end
        for (int k = 0; k < 9; k++) begin
            win_px[k] = '0;
        end
    end

    function automatic int unsigned clamp_width(input logic [WID_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return raw;
    endfunction

    function automatic int unsigned clamp_height(input logic [HGT_W-1:0] raw);
        return (raw == 0) ? 1 : raw;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log readable when a large frame goes wrong
        if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Predictor: gray conversion, line stores, window and kernel threshold
    // ------------------------------------------------------------------------
    function automatic void clear_raster();
        ras_col   = 0;
        ras_row   = 0;
        res_count = '0;
    endfunction

    function automatic void apply_register(input t_cfg_idx idx, input logic [CDAT_W-1:0] data);
        case (idx)
            CFG_WIDTH:     reg_width     = data[WID_W-1:0];
            CFG_HEIGHT:    reg_height    = data[HGT_W-1:0];
            CFG_DIRECTION: reg_direction = data[0];
            CFG_THRESHOLD: reg_threshold = data[THR_W-1:0];
            CFG_BLUE_WGT:  reg_blue_w    = data[WGT_W-1:0];
            CFG_GREEN_WGT: reg_green_w   = data[WGT_W-1:0];
            CFG_RED_WGT:   reg_red_w     = data[WGT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void sobel_predict(input logic cmd, input logic [PIX_W-1:0] blu,
                                          input logic [PIX_W-1:0] grn,
                                          input logic [PIX_W-1:0] red);
        int unsigned w, h, total, gray, col, orow, ocol, mag;
        int unsigned wb, wg, wr, cb, cg, cr;
        int          grad;
        int          p [9];
        logic [PIX_W-1:0] top, mid;
        pix_result_t res;
        w     = clamp_width(reg_width);
        h     = clamp_height(reg_height);
        total = w * h;
        if (res_count >= total) clear_raster();
        // drop a flush when the frame has not started
        if (cmd == CMD_FLUSH && ras_row == 0 && ras_col == 0) return;
        if (cmd == CMD_FLUSH) begin
            gray = 0;
        end else begin
            wb = reg_blue_w;
            wg = reg_green_w;
            wr = reg_red_w;
            cb = blu;
            cg = grn;
            cr = red;
            gray = (wb * cb + wg * cg + wr * cr) >> 16;
            if (gray > 255) gray = 255;
        end
        // read both line stores, shift the window, write back
        col = ras_col;
        top = gray_row2[col];
        mid = gray_row1[col];
        for (int k = 0; k < 3; k++) begin
            win_px[k*3]   = win_px[k*3+1];
            win_px[k*3+1] = win_px[k*3+2];
        end
        win_px[2] = top;
        win_px[5] = mid;
        win_px[8] = gray[PIX_W-1:0];
        gray_row2[col] = mid;
        gray_row1[col] = gray[PIX_W-1:0];
        // emit once the window center lags by one row plus one pixel
        if (ras_row >= 2 || (ras_row == 1 && ras_col >= 1)) begin
            if (ras_col >= 1) begin
                ocol = ras_col - 1;
                orow = ras_row - 1;
            end else begin
                ocol = w - 1;
                orow = ras_row - 2;
            end
            if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
                res.value = win_px[4];
            end else begin
                for (int k = 0; k < 9; k++) p[k] = win_px[k];
                if (reg_direction == DIR_Y)
                    grad = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
                else
                    grad = (p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]);
                mag = (grad < 0) ? -grad : grad;
                res.value = (mag >= reg_threshold) ? PIX_MAX : PIX_ZERO;
            end
            res.frame_end = (res_count == total - 1);
            result_q.push_back(res);
            res_count = res_count + 1'b1;
        end
        // advance the raster position
        ras_col++;
        if (ras_col >= w) begin
            ras_col = 0;
            ras_row++;
        end
        if (res_count >= total) clear_raster();
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic void push_item(input logic cmd, input logic [PIX_W-1:0] b,
                                      input logic [PIX_W-1:0] g,
                                      input logic [PIX_W-1:0] r);
        stim_step_t s;
        s.kind     = STEP_PIXEL;
        s.cmd      = cmd;
        s.blue     = b;
        s.green    = g;
        s.red      = r;
        s.reg_idx  = CFG_WIDTH;
        s.reg_data = '0;
        step_q.push_back(s);
    endfunction

    function automatic void push_pause();
        stim_step_t s;
        s.kind     = STEP_PAUSE;
        s.cmd      = CMD_PIXEL;
        s.blue     = '0;
        s.green    = '0;
        s.red      = '0;
        s.reg_idx  = CFG_WIDTH;
        s.reg_data = '0;
        step_q.push_back(s);
    endfunction

    function automatic void push_cfg(input t_cfg_idx idx, input logic [CDAT_W-1:0] data);
        stim_step_t s;
        s.kind     = STEP_WRITE;
        s.cmd      = CMD_PIXEL;
        s.blue     = '0;
        s.green    = '0;
        s.red      = '0;
        s.reg_idx  = idx;
        s.reg_data = data;
        step_q.push_back(s);
        if (idx == CFG_WIDTH)  gen_width  = data[WID_W-1:0];
        if (idx == CFG_HEIGHT) gen_height = data[HGT_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] near_level(input int level);
        int v;
        v = level + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
    endfunction

    // One whole frame plus the ticks that drain it.
    // Modes: 0 random, 1 flat with noise, 2 step edge, 3 random with flushes.
    function automatic void push_frame(input int mode);
        int w, h, n, base, lo, hi, split, pause_at;
        logic vert, on_hi;
        logic [PIX_W-1:0] v;
        w        = clamp_width(gen_width);
        h        = clamp_height(gen_height);
        n        = w * h;
        base     = $urandom_range(0, 255);
        lo       = $urandom_range(0, 90);
        hi       = $urandom_range(140, 255);
        vert     = $urandom_range(0, 1);
        split    = vert ? $urandom_range(0, w) : $urandom_range(0, h);
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int k = 0; k < n + w + 1; k++) begin
            if (k == pause_at) push_pause();
            if (k >= n) begin
                // drain: flush ticks, or pixels beyond the frame
                if ($urandom_range(0, 1) == 0)
                    push_item(CMD_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
                else
                    push_item(CMD_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
            end else begin
                case (mode)
                    1: begin
                        push_item(CMD_PIXEL, near_level(base), near_level(base),
                                  near_level(base));
                    end
                    2: begin
                        on_hi = vert ? ((k % w) >= split) : ((k / w) >= split);
                        v = near_level(on_hi ? hi : lo);
                        push_item(CMD_PIXEL, v, near_level(on_hi ? hi : lo), v);
                    end
                    3: begin
                        push_item(($urandom_range(0, 5) == 0) ? CMD_FLUSH : CMD_PIXEL,
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255));
                    end
                    default: begin
                        push_item(CMD_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255));
                    end
                endcase
            end
        end
        frame_items += n + w + 1;
        // a flush between frames finds nothing pending
        if ($urandom_range(0, 4) == 0) push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    endfunction

    function automatic logic [CDAT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 21845);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pixel and register channels fed from the step queue
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stim_step_t nxt;
        logic       drive_pix;
        logic       drive_cfg;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            // predict on each completed transfer
            if (i_valid && !o_stall) sobel_predict(i_cmd, i_blue_in, i_green_in, i_red_in);
            if (i_cfg_valid && o_cfg_ready) apply_register(t_cfg_idx'(i_cfg_index), i_cfg_data);
            // hold while a transfer is pending, else pick the next step
            if (!(i_valid && o_stall) && !(i_cfg_valid && !o_cfg_ready)) begin
                drive_pix = 1'b0;
                drive_cfg = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (step_q.size() != 0) begin
                    nxt = step_q[0];
                    case (nxt.kind)
                        STEP_PIXEL: begin
                            void'(step_q.pop_front());
                            drive_pix = 1'b1;
                            i_cmd      <= nxt.cmd;
                            i_blue_in  <= nxt.blue;
                            i_green_in <= nxt.green;
                            i_red_in   <= nxt.red;
                            if (burst_left <= 1) begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                         : $urandom_range(1, 6);
                            end else begin
                                burst_left--;
                            end
                        end
                        STEP_PAUSE: begin
                            // wait for every result, then let the pipeline settle
                            if (result_q.size() != 0) begin
                                settle_left = SETTLE;
                            end else if (settle_left != 0) begin
                                settle_left--;
                            end else begin
                                void'(step_q.pop_front());
                                settle_left = SETTLE;
                            end
                        end
                        default: begin
                            void'(step_q.pop_front());
                            drive_cfg = 1'b1;
                            i_cfg_index <= nxt.reg_idx;
                            i_cfg_data  <= nxt.reg_data;
                        end
                    endcase
                end
                i_valid     <= drive_pix;
                i_cfg_valid <= drive_cfg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer and drive the stall pattern
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        pix_result_t want;
        logic        stall_nxt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pixel_value=%0d last=%0b",
                                              o_pixel_value, o_last_of_frame));
                end else begin
                    want = result_q.pop_front();
                    if (o_pixel_value !== want.value)
                        report_mismatch($sformatf("pixel_value got %0d want %0d",
                                                  o_pixel_value, want.value));
                    if (o_last_of_frame !== want.frame_end)
                        report_mismatch($sformatf("last_of_frame got %0b want %0b",
                                                  o_last_of_frame, want.frame_end));
                end
            end
            // switch between free flow, light, heavy and periodic stalls
            if (pat_left == 0) begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(20, 120);
            end else begin
                pat_left--;
            end
            case (pat_mode)
                0:       stall_nxt = 1'b0;
                1:       stall_nxt = ($urandom_range(0, 3) == 0);
                2:       stall_nxt = ($urandom_range(0, 3) != 0);
                default: stall_nxt = ((pat_left % 3) == 0);
            endcase
            i_stall <= stall_nxt;
        end
    end

    // Count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int goal;
        int nfr;
        logic [PIX_W-1:0] hv;

        // Directed: a 5x3 frame of saturated channel patterns
        push_cfg(CFG_WIDTH, 16'd5);
        push_cfg(CFG_HEIGHT, 16'd3);
        push_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        for (int k = 0; k < 15; k++) begin
            hv = (k % 2) ? 8'hFF : 8'h00;
            case (k % 4)
                0: push_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
                1: push_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
                2: push_item(CMD_PIXEL, 8'hFF, hv, 8'h00);
                default: push_item(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF);
            endcase
        end
        push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        push_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        push_item(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
        push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        push_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
        push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

        // Directed: y kernel at both threshold extremes
        push_pause();
        push_cfg(CFG_DIRECTION, 16'(DIR_Y));
        push_cfg(CFG_THRESHOLD, 16'd0);
        push_cfg(CFG_WIDTH, 16'd3);
        push_cfg(CFG_HEIGHT, 16'd3);
        push_frame(0);
        push_pause();
        push_cfg(CFG_THRESHOLD, 16'd1023);
        push_frame(2);

        // Directed: zero width and height act as one
        push_pause();
        push_cfg(CFG_WIDTH, 16'd0);
        push_cfg(CFG_HEIGHT, 16'd0);
        push_frame(0);

        // Directed: shrink the height mid-frame below the results already sent
        push_pause();
        push_cfg(CFG_DIRECTION, 16'(DIR_X));
        push_cfg(CFG_THRESHOLD, 16'd70);
        push_cfg(CFG_WIDTH, 16'd4);
        push_cfg(CFG_HEIGHT, 16'd6);
        for (int k = 0; k < 16; k++)
            push_item(CMD_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        push_pause();
        push_cfg(CFG_HEIGHT, 16'd2);
        push_frame(0);

        // Largest sizes: width above the store depth, tallest height
        push_pause();
        push_cfg(CFG_WIDTH, 16'd4095);
        push_cfg(CFG_HEIGHT, 16'd3);
        push_frame(2);
        push_pause();
        push_cfg(CFG_WIDTH, 16'd1);
        push_cfg(CFG_HEIGHT, 16'd8191);
        push_frame(0);
        push_pause();
        push_cfg(CFG_WIDTH, 16'd6);
        push_cfg(CFG_HEIGHT, 16'd4);

        // Random phases of register settings and small frames
        goal = frame_items + 450;
        while (frame_items < goal) begin
            push_pause();
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0:       push_cfg(CFG_WIDTH, 16'd0);
                    1:       push_cfg(CFG_WIDTH, $urandom_range(11, 40));
                    2:       push_cfg(CFG_WIDTH, 16'd3);
                    default: push_cfg(CFG_WIDTH, $urandom_range(1, 10));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0:       push_cfg(CFG_HEIGHT, 16'd0);
                    1:       push_cfg(CFG_HEIGHT, $urandom_range(9, 16));
                    default: push_cfg(CFG_HEIGHT, $urandom_range(1, 8));
                endcase
            end
            if ($urandom_range(0, 1) != 0) push_cfg(CFG_DIRECTION, $urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 3))
                    0:       push_cfg(CFG_THRESHOLD, 16'd0);
                    1:       push_cfg(CFG_THRESHOLD, 16'd1023);
                    2:       push_cfg(CFG_THRESHOLD, $urandom_range(0, 1023));
                    default: push_cfg(CFG_THRESHOLD, $urandom_range(0, 300));
                endcase
            end
            if ($urandom_range(0, 1) != 0) push_cfg(CFG_BLUE_WGT, pick_weight());
            if ($urandom_range(0, 1) != 0) push_cfg(CFG_GREEN_WGT, pick_weight());
            if ($urandom_range(0, 1) != 0) push_cfg(CFG_RED_WGT, pick_weight());
            nfr = $urandom_range(1, 2);
            for (int f = 0; f < nfr; f++) push_frame($urandom_range(0, 3));
        end

        // Release reset, then wait for the queue and the results to drain
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (step_q.size() != 0 || i_valid || i_cfg_valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
